FILE: hw/rtl/cop_pkg.sv
`timescale 1ns / 1ps
package cop_pkg;
    localparam int COORD_BITS = 24;
    localparam int RAD_BITS   = COORD_BITS - 2;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int ROOT_BITS  = DIFF_BITS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int DEP_BITS   = RAD_BITS + 1;
    localparam int NUM_BITS   = DIFF_BITS + DEP_BITS + 1;
    localparam int QUO_BITS   = DEP_BITS + 1;
    localparam int RATE_BITS  = 16;
    localparam int RATE_FRAC  = 15;
    localparam int PROD_BITS  = QUO_BITS + RATE_BITS;
    localparam int MAG_BITS   = PROD_BITS + 1 - RATE_FRAC;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam logic [RATE_BITS-1:0] RATE_RESET = 16'd32768;

    typedef struct packed {
        logic [DIFF_BITS-1:0] ax;
        logic [DIFF_BITS-1:0] ay;
        logic                 sx;
        logic                 sy;
        logic [ROOT_BITS-1:0] len;
        logic [DEP_BITS-1:0]  depth;
        logic                 ov;
    } t_job;

    typedef struct packed {
        logic [DIFF_BITS-1:0] ax;
        logic [DIFF_BITS-1:0] ay;
        logic                 sx;
        logic                 sy;
        logic [DEP_BITS-1:0]  rsum;
    } t_side;

    typedef struct packed {
        logic push;
        logic full;
    } t_qwr;

    typedef struct packed {
        logic pop;
        logic empty;
    } t_qrd;
endpackage

FILE: hw/rtl/circle_overlap_push_vector.sv
`timescale 1ns / 1ps
// Channel   | Handshake                      | Payload
// request   | i_in_valid / o_in_stall        | i_self_*, i_other_*
// result    | o_out_valid / i_out_stall      | o_move_x, o_move_y, o_hit
// config    | i_cfg_we                       | i_cfg_wdata (push_rate)
// One request per cycle sustained while the queue has room; a request passes through the
// front (square, sum, one root bit per stage), into the 4-entry queue,
// then through the back (one quotient bit per divider stage).
// Synchronous active-low reset clears valids and queue pointers, loads push_rate with 1.0.
// Result stalls hold the back; the front keeps running until the queue fills.
module circle_overlap_push_vector import cop_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [RATE_BITS-1:0]         i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_self_x,
    input  logic signed [COORD_BITS-1:0] i_self_y,
    input  logic        [RAD_BITS-1:0]   i_self_radius,
    input  logic signed [COORD_BITS-1:0] i_other_x,
    input  logic signed [COORD_BITS-1:0] i_other_y,
    input  logic        [RAD_BITS-1:0]   i_other_radius,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_move_x,
    output logic signed [COORD_BITS-1:0] o_move_y,
    output logic                         o_hit
);
    logic [RATE_BITS-1:0] r_push_rate;
    logic                 adv;
    logic                 push;
    logic                 pop;
    t_job                 job_in;
    t_job                 job_out;
    t_qwr                 qwr;
    t_qrd                 qrd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_push_rate <= i_cfg_wdata;
        end
    end

    cop_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_adv          (adv),
        .i_self_x       (i_self_x),
        .i_self_y       (i_self_y),
        .i_self_radius  (i_self_radius),
        .i_other_x      (i_other_x),
        .i_other_y      (i_other_y),
        .i_other_radius (i_other_radius),
        .i_qwr          (qwr),
        .o_push         (push),
        .o_job          (job_in)
    );

    cop_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_wr    (qwr),
        .o_rd    (qrd),
        .o_data  (job_out)
    );

    cop_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rate      (r_push_rate),
        .i_qrd       (qrd),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_move_x    (o_move_x),
        .o_move_y    (o_move_y),
        .o_hit       (o_hit)
    );

    assign o_in_stall = !adv;
endmodule

FILE: hw/rtl/cop_sqrt.sv
`timescale 1ns / 1ps
module cop_sqrt import cop_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SQ_BITS-1:0]   i_rad,
    output logic [ROOT_BITS-1:0] o_root
);
    logic [SQ_BITS-1:0]   r_rad  [ROOT_BITS];
    logic [REM_BITS-1:0]  r_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_root [ROOT_BITS];
    logic [SQ_BITS-1:0]   n_rad  [ROOT_BITS];
    logic [REM_BITS-1:0]  n_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0] n_root [ROOT_BITS];

    always_comb begin
        logic [SQ_BITS-1:0]    s_rad;
        logic [REM_BITS-1:0]   s_rem;
        logic [ROOT_BITS-1:0]  s_root;
        logic [REM_BITS+1:0]   rem2;
        logic [REM_BITS+1:0]   trial;
        for (int k = 0; k < ROOT_BITS; k++) begin
            if (k == 0) begin
                s_rad  = i_rad;
                s_rem  = '0;
                s_root = '0;
            end else begin
                s_rad  = r_rad[k-1];
                s_rem  = r_rem[k-1];
                s_root = r_root[k-1];
            end
            rem2  = {s_rem, s_rad[SQ_BITS-1:SQ_BITS-2]};
            trial = {2'b00, s_root, 2'b01};
            n_rad[k] = {s_rad[SQ_BITS-3:0], 2'b00};
            if (rem2 >= trial) begin
                n_rem[k]  = REM_BITS'(rem2 - trial);
                n_root[k] = {s_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem2[REM_BITS-1:0];
                n_root[k] = {s_root[ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_BITS; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[ROOT_BITS-1];
endmodule

FILE: hw/rtl/cop_div.sv
`timescale 1ns / 1ps
module cop_div import cop_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [ROOT_BITS-1:0] i_den,
    output logic [QUO_BITS-1:0]  o_quo
);
    logic [NUM_BITS-1:0]  r_rem [QUO_BITS];
    logic [ROOT_BITS-1:0] r_den [QUO_BITS];
    logic [QUO_BITS-1:0]  r_quo [QUO_BITS];
    logic [NUM_BITS-1:0]  n_rem [QUO_BITS];
    logic [QUO_BITS-1:0]  n_quo [QUO_BITS];

    always_comb begin
        logic [NUM_BITS-1:0]  s_rem;
        logic [ROOT_BITS-1:0] s_den;
        logic [QUO_BITS-1:0]  s_quo;
        logic [NUM_BITS-1:0]  cmp;
        for (int k = 0; k < QUO_BITS; k++) begin
            if (k == 0) begin
                s_rem = i_num;
                s_den = i_den;
                s_quo = '0;
            end else begin
                s_rem = r_rem[k-1];
                s_den = r_den[k-1];
                s_quo = r_quo[k-1];
            end
            cmp = NUM_BITS'(s_den) << (QUO_BITS - 1 - k);
            if (s_rem >= cmp) begin
                n_rem[k] = s_rem - cmp;
                n_quo[k] = {s_quo[QUO_BITS-2:0], 1'b1};
            end else begin
                n_rem[k] = s_rem;
                n_quo[k] = {s_quo[QUO_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_BITS; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= (k == 0) ? i_den : r_den[k-1];
            end
        end
    end

    assign o_quo = r_quo[QUO_BITS-1];
endmodule

FILE: hw/rtl/cop_fifo.sv
`timescale 1ns / 1ps
module cop_fifo import cop_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_qwr o_wr,
    output t_qrd o_rd,
    output t_job o_data
);
    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic              full;
    logic              empty;
    logic              do_push;
    logic              do_pop;

    assign full    = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign empty   = (r_cnt == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    assign o_data     = r_mem[r_rp];
    assign o_wr.push  = do_push;
    assign o_wr.full  = full;
    assign o_rd.pop   = do_pop;
    assign o_rd.empty = empty;
endmodule

FILE: hw/rtl/cop_front.sv
`timescale 1ns / 1ps
module cop_front import cop_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_adv,
    input  logic signed [COORD_BITS-1:0] i_self_x,
    input  logic signed [COORD_BITS-1:0] i_self_y,
    input  logic        [RAD_BITS-1:0]   i_self_radius,
    input  logic signed [COORD_BITS-1:0] i_other_x,
    input  logic signed [COORD_BITS-1:0] i_other_y,
    input  logic        [RAD_BITS-1:0]   i_other_radius,
    input  t_qwr                         i_qwr,
    output logic                         o_push,
    output t_job                         o_job
);
    logic                 adv;
    logic [DIFF_BITS-1:0] dx;
    logic [DIFF_BITS-1:0] dy;
    t_side                n_a;
    t_side                r_a;
    t_side                r_b;
    t_side                r_c;
    t_side                r_sd [ROOT_BITS];
    logic                 r_va;
    logic                 r_vb;
    logic                 r_vc;
    logic                 r_vs [ROOT_BITS];
    logic [SQ_BITS-1:0]   r_sqx;
    logic [SQ_BITS-1:0]   r_sqy;
    logic [SQ_BITS-1:0]   r_rad;
    logic [ROOT_BITS-1:0] root;
    t_side                last;

    assign adv = !r_vs[ROOT_BITS-1] || !i_qwr.full;

    assign dx = {i_self_x[COORD_BITS-1], i_self_x} - {i_other_x[COORD_BITS-1], i_other_x};
    assign dy = {i_self_y[COORD_BITS-1], i_self_y} - {i_other_y[COORD_BITS-1], i_other_y};

    always_comb begin
        n_a.sx   = dx[DIFF_BITS-1];
        n_a.sy   = dy[DIFF_BITS-1];
        n_a.ax   = dx[DIFF_BITS-1] ? (~dx + 1'b1) : dx;
        n_a.ay   = dy[DIFF_BITS-1] ? (~dy + 1'b1) : dy;
        n_a.rsum = DEP_BITS'(i_self_radius) + DEP_BITS'(i_other_radius);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            for (int k = 0; k < ROOT_BITS; k++) r_vs[k] <= 1'b0;
        end else if (adv) begin
            r_va <= i_in_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            for (int k = 0; k < ROOT_BITS; k++) r_vs[k] <= (k == 0) ? r_vc : r_vs[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a   <= n_a;
            r_b   <= r_a;
            r_sqx <= SQ_BITS'(r_a.ax) * SQ_BITS'(r_a.ax);
            r_sqy <= SQ_BITS'(r_a.ay) * SQ_BITS'(r_a.ay);
            r_c   <= r_b;
            r_rad <= r_sqx + r_sqy;
            for (int k = 0; k < ROOT_BITS; k++) r_sd[k] <= (k == 0) ? r_c : r_sd[k-1];
        end
    end

    cop_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  (r_rad),
        .o_root (root)
    );

    assign last = r_sd[ROOT_BITS-1];

    always_comb begin
        o_job.ax    = last.ax;
        o_job.ay    = last.ay;
        o_job.sx    = last.sx;
        o_job.sy    = last.sy;
        o_job.len   = root;
        o_job.ov    = (root != '0) && (ROOT_BITS'(last.rsum) > root);
        o_job.depth = DEP_BITS'(ROOT_BITS'(last.rsum) - root);
    end

    assign o_push = r_vs[ROOT_BITS-1] && !i_qwr.full;
    assign o_adv  = adv;
endmodule

FILE: hw/rtl/cop_back.sv
`timescale 1ns / 1ps
module cop_back import cop_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [RATE_BITS-1:0]         i_rate,
    input  t_qrd                         i_qrd,
    input  t_job                         i_job,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_move_x,
    output logic signed [COORD_BITS-1:0] o_move_y,
    output logic                         o_hit
);
    typedef struct packed {
        logic sx;
        logic sy;
        logic ov;
    } t_tag;

    localparam logic [MAG_BITS-1:0] LIM = MAG_BITS'(1) << (COORD_BITS - 1);
    localparam logic [COORD_BITS-1:0] MAXP = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] MINN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                 adv;
    logic                 r_vp;
    logic                 r_vd [QUO_BITS];
    logic                 r_vm;
    logic                 r_vo;
    logic [NUM_BITS-1:0]  r_numx;
    logic [NUM_BITS-1:0]  r_numy;
    logic [ROOT_BITS-1:0] r_len;
    t_tag                 r_pt;
    t_tag                 r_dt [QUO_BITS];
    logic [QUO_BITS-1:0]  qx;
    logic [QUO_BITS-1:0]  qy;
    logic [PROD_BITS-1:0] r_mx;
    logic [PROD_BITS-1:0] r_my;
    logic                 r_msx;
    logic                 r_msy;
    logic                 r_mhit;
    logic [MAG_BITS-1:0]  magx;
    logic [MAG_BITS-1:0]  magy;
    logic [PROD_BITS:0]   sumx;
    logic [PROD_BITS:0]   sumy;
    logic [COORD_BITS-1:0] r_ox;
    logic [COORD_BITS-1:0] r_oy;
    logic                 r_oh;

    function automatic logic [COORD_BITS-1:0] sat(input logic [MAG_BITS-1:0] m,
                                                  input logic neg);
        logic [COORD_BITS-1:0] v;
        if (!neg) begin
            v = (m >= LIM) ? MAXP : m[COORD_BITS-1:0];
        end else begin
            v = (m > LIM) ? MINN : (~m[COORD_BITS-1:0] + 1'b1);
        end
        return v;
    endfunction

    assign adv   = !r_vo || !i_out_stall;
    assign o_pop = !i_qrd.empty && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vm <= 1'b0;
            r_vo <= 1'b0;
            for (int k = 0; k < QUO_BITS; k++) r_vd[k] <= 1'b0;
        end else if (adv) begin
            r_vp <= !i_qrd.empty;
            for (int k = 0; k < QUO_BITS; k++) r_vd[k] <= (k == 0) ? r_vp : r_vd[k-1];
            r_vm <= r_vd[QUO_BITS-1];
            r_vo <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_numx <= NUM_BITS'(i_job.ax) * NUM_BITS'(i_job.depth)
                      + NUM_BITS'(i_job.len >> 1);
            r_numy <= NUM_BITS'(i_job.ay) * NUM_BITS'(i_job.depth)
                      + NUM_BITS'(i_job.len >> 1);
            r_len  <= i_job.len;
            r_pt   <= '{sx: i_job.sx, sy: i_job.sy, ov: i_job.ov};
            for (int k = 0; k < QUO_BITS; k++) r_dt[k] <= (k == 0) ? r_pt : r_dt[k-1];
            r_mx   <= PROD_BITS'(qx) * PROD_BITS'(i_rate);
            r_my   <= PROD_BITS'(qy) * PROD_BITS'(i_rate);
            r_msx  <= r_dt[QUO_BITS-1].sx;
            r_msy  <= r_dt[QUO_BITS-1].sy;
            r_mhit <= r_dt[QUO_BITS-1].ov && ((qx != '0) || (qy != '0));
            r_oh   <= r_mhit;
            r_ox   <= r_mhit ? sat(magx, r_msx) : '0;
            r_oy   <= r_mhit ? sat(magy, r_msy) : '0;
        end
    end

    cop_div u_div_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_numx),
        .i_den (r_len),
        .o_quo (qx)
    );

    cop_div u_div_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_numy),
        .i_den (r_len),
        .o_quo (qy)
    );

    assign sumx = (PROD_BITS+1)'(r_mx) + (PROD_BITS+1)'(1 << (RATE_FRAC - 1));
    assign sumy = (PROD_BITS+1)'(r_my) + (PROD_BITS+1)'(1 << (RATE_FRAC - 1));
    assign magx = sumx[PROD_BITS:RATE_FRAC];
    assign magy = sumy[PROD_BITS:RATE_FRAC];

    assign o_out_valid = r_vo;
    assign o_move_x    = r_ox;
    assign o_move_y    = r_oy;
    assign o_hit       = r_oh;
endmodule

FILE: hw/rtl/cop_checker.sv
`timescale 1ns / 1ps
module cop_checker import cop_pkg::*; (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic signed [COORD_BITS-1:0] o_move_x,
    input logic signed [COORD_BITS-1:0] o_move_y,
    input logic                         o_hit
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_move_x) && $stable(o_move_y)
                                       && $stable(o_hit))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> (o_move_x == '0) && (o_move_y == '0))
        else $error("nonzero move without hit");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind circle_overlap_push_vector cop_checker u_cop_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_move_x    (o_move_x),
    .o_move_y    (o_move_y),
    .o_hit       (o_hit)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import cop_pkg::*;

    localparam int N_RANDOM  = 1330;
    localparam int DRAIN_CYC = 80;
    localparam int WD_LIMIT  = 2000;

    typedef struct {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic        [RAD_BITS-1:0]   sr;
        logic signed [COORD_BITS-1:0] ox;
        logic signed [COORD_BITS-1:0] oy;
        logic        [RAD_BITS-1:0]   orad;
        bit                           fixed_exp;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic                         eh;
    } t_circle_row;

    typedef struct {
        logic signed [COORD_BITS-1:0] mx;
        logic signed [COORD_BITS-1:0] my;
        logic                         hit;
    } t_push;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [RATE_BITS-1:0]         i_cfg_wdata = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic signed [COORD_BITS-1:0] i_self_x = '0;
    logic signed [COORD_BITS-1:0] i_self_y = '0;
    logic        [RAD_BITS-1:0]   i_self_radius = '0;
    logic signed [COORD_BITS-1:0] i_other_x = '0;
    logic signed [COORD_BITS-1:0] i_other_y = '0;
    logic        [RAD_BITS-1:0]   i_other_radius = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic signed [COORD_BITS-1:0] o_move_x;
    logic signed [COORD_BITS-1:0] o_move_y;
    logic                         o_hit;

    circle_overlap_push_vector i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [RATE_BITS-1:0] rate_model = RATE_RESET;
    t_push   push_q[$];
    int      err_cnt = 0;
    int      idle_cyc = 0;
    bit      calm = 1'b0;

    function automatic logic [63:0] floor_root(input logic [64:0] v);
        logic [66:0] rem;
        logic [64:0] root;
        rem = '0;
        root = '0;
        for (int k = 64; k >= 0; k -= 2) begin
            rem = (rem << 2) | ((v >> k) & 65'd3);
            if (rem >= {root, 2'b01}) begin
                rem = rem - {root, 2'b01};
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root[63:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[COORD_BITS-1:0];
        if (v < lo) return lo[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    function automatic t_push predict_push(input t_circle_row r);
        t_push  p;
        longint dx, dy;
        logic [63:0] ax, ay, len, rsum, depth, px, py, mx, my;
        p = '{0, 0, 0};
        dx = longint'(r.sx) - longint'(r.ox);
        dy = longint'(r.sy) - longint'(r.oy);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        len = floor_root({1'b0, ax * ax} + {1'b0, ay * ay});
        rsum = 64'(r.sr) + 64'(r.orad);
        if (len == 0 || rsum <= len) return p;
        depth = rsum - len;
        px = (ax * depth + (len >> 1)) / len;
        py = (ay * depth + (len >> 1)) / len;
        if (px == 0 && py == 0) return p;
        mx = (px * rate_model + (64'd1 << (RATE_FRAC - 1))) >> RATE_FRAC;
        my = (py * rate_model + (64'd1 << (RATE_FRAC - 1))) >> RATE_FRAC;
        p.mx = clamp_coord(dx < 0 ? -longint'(mx) : longint'(mx));
        p.my = clamp_coord(dy < 0 ? -longint'(my) : longint'(my));
        p.hit = 1'b1;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_push e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (push_q.size() == 0) begin
                $error("result with none expected");
                err_cnt++;
            end else begin
                e = push_q.pop_front();
                if (o_move_x !== e.mx) begin
                    $error("move_x expected %0d got %0d", e.mx, o_move_x);
                    err_cnt++;
                end
                if (o_move_y !== e.my) begin
                    $error("move_y expected %0d got %0d", e.my, o_move_y);
                    err_cnt++;
                end
                if (o_hit !== e.hit) begin
                    $error("hit expected %0d got %0d", e.hit, o_hit);
                    err_cnt++;
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cyc <= 0;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
        if (idle_cyc >= WD_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(input t_circle_row r);
        t_push e;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_self_x <= r.sx;
        i_self_y <= r.sy;
        i_self_radius <= r.sr;
        i_other_x <= r.ox;
        i_other_y <= r.oy;
        i_other_radius <= r.orad;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        e = predict_push(r);
        if (r.fixed_exp) e = '{r.ex, r.ey, r.eh};
        push_q.push_back(e);
    endtask

    task automatic drain_and_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (push_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_BITS-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rate_model = v;
    endtask

    function automatic logic signed [COORD_BITS-1:0] rand_coord(input int mode);
        case (mode)
            0: return COORD_BITS'($urandom());
            1: return COORD_BITS'($signed($urandom_range(0, 8000)) - 4000);
            default: return COORD_BITS'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    function automatic t_circle_row rand_row();
        t_circle_row r;
        int mode;
        mode = $urandom_range(0, 3);
        r.fixed_exp = 0;
        r.sx = rand_coord(mode);
        r.sy = rand_coord(mode);
        if ($urandom_range(0, 4) == 0) begin
            r.ox = r.sx + COORD_BITS'($signed($urandom_range(0, 20)) - 10);
            r.oy = r.sy + COORD_BITS'($signed($urandom_range(0, 20)) - 10);
        end else begin
            r.ox = rand_coord(mode);
            r.oy = rand_coord(mode);
        end
        if (mode == 0 || $urandom_range(0, 5) == 0) begin
            r.sr = RAD_BITS'($urandom());
            r.orad = RAD_BITS'($urandom());
        end else begin
            r.sr = RAD_BITS'($urandom_range(0, mode == 1 ? 6000 : 300000));
            r.orad = RAD_BITS'($urandom_range(0, mode == 1 ? 6000 : 300000));
        end
        return r;
    endfunction

    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [RAD_BITS-1:0] RMAX = '1;

    t_circle_row directed_rows[] = '{
        '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
        '{100, 200, RMAX, 100, 200, RMAX, 1, 0, 0, 0},
        '{0, 0, 10, 1000, 0, 10, 1, 0, 0, 0},
        '{0, 0, 500, 1000, 0, 500, 1, 0, 0, 0},
        '{0, 0, 600, 1000, 0, 500, 1, -100, 0, 1},
        '{0, 0, 600, 0, -1000, 500, 1, 0, 100, 1},
        '{3, 4, 5, 0, 0, 1, 1, 1, 1, 1},
        '{100000, 0, 1, 0, 0, 1, 0, 0, 0, 0},
        '{1, 1, 0, 0, 0, 1, 0, 0, 0, 0},
        '{CMAX, CMAX, RMAX, CMIN, CMIN, RMAX, 0, 0, 0, 0},
        '{CMIN, CMAX, RMAX, CMAX, CMIN, RMAX, 0, 0, 0, 0},
        '{CMAX, 0, RMAX, CMAX - 1, 0, RMAX, 0, 0, 0, 0},
        '{CMIN, 0, RMAX, CMIN + 1, 0, RMAX, 0, 0, 0, 0},
        '{-7, 13, 40, 9, -20, 3, 0, 0, 0, 0},
        '{123456, -654321, 2000000, -99999, 77777, 1500000, 0, 0, 0, 0},
        '{0, 5, RMAX, 0, -5, 0, 0, 0, 0, 0}
    };

    logic [RATE_BITS-1:0] rate_plan[] = '{16'd0, 16'd32768, 16'hFFFF, 16'd16384, 16'd1};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i]) send_request(directed_rows[i]);
        drain_and_idle();
        foreach (rate_plan[p]) begin
            write_rate(rate_plan[p]);
            foreach (directed_rows[i]) begin
                if (!directed_rows[i].fixed_exp) send_request(directed_rows[i]);
            end
            for (int n = 0; n < N_RANDOM / 6; n++) send_request(rand_row());
            drain_and_idle();
        end
        write_rate(RATE_BITS'($urandom()));
        calm = 1'b1;
        for (int n = 0; n < N_RANDOM / 6; n++) send_request(rand_row());
        drain_and_idle();
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
